// ===== rtl/core/best_fit_extent_allocator_top_macros.svh =====
// Assertion macros shared by the allocator checkers.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BEST_FIT_EXTENT_ALLOCATOR_TOP_MACROS_SVH
`define BEST_FIT_EXTENT_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication
`define BFEA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BFEA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bfea_pkg.sv =====
// Package for the best-fit extent allocator: sizes, codes, item types.
// No dependencies.
package bfea_pkg;

  localparam int NUM_EXTENTS   = 64;
  localparam int IDX_W         = $clog2(NUM_EXTENTS);
  localparam int GRANULE_BYTES = 8;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_FIT  = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  localparam logic CFG_POOL_START  = 1'b0;
  localparam logic CFG_POOL_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_A,
    S_SCAN_T,
    S_SCAN_PN,
    S_UPDATE
  } state_e;

  typedef struct packed {
    logic        command;
    logic [31:0] request_bytes;
    logic [31:0] release_addr;
    logic [31:0] release_bytes;
  } bfea_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] grant_addr;
    logic [31:0] grant_bytes;
  } bfea_out_t;

endpackage

// ===== rtl/core/best_fit_extent_allocator_top.sv =====
// Best-fit extent allocator: extent table in a synchronous RAM, scan FSM.
// Depends on bfea_pkg.
//
// Usage: raise start_i with item_i while busy_o is low; the item is taken
// at that edge and busy_o rises. One result per item appears on result_o for
// a single cycle, marked by result_valid_o, together with busy_o falling.
// Timing is set by the single read port of the extent RAM, one entry a cycle:
//   allocate: one pass over the 64 entries;
//   free: two passes (neighbour, then predecessor/successor), or one
//   when no extent reaches the block;
//   free with an address out of range: no pass.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high. A write resets the table to one extent covering the
// pool at once, through per-entry live flops; no clearing pass is needed.
// Reset clears both registers and leaves one empty live extent at entry 0.
// The receiver cannot stall; results must be taken in their strobe cycle.
module best_fit_extent_allocator_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  bfea_pkg::bfea_in_t   item_i,
  output logic                 result_valid_o,
  output bfea_pkg::bfea_out_t  result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import bfea_pkg::*;

  localparam logic [32:0] GranAdd  = 33'(2 * GRANULE_BYTES - 1);
  localparam logic [32:0] GranMask = ~33'(GRANULE_BYTES - 1);
  localparam logic [IDX_W:0] ScanEnd = (IDX_W + 1)'(NUM_EXTENTS);

  state_e state_q, state_d;

  logic [31:0] pool_start_q, pool_length_q;
  logic [NUM_EXTENTS-1:0] live_q, live_d;
  logic init0_q, init0_d;

  bfea_in_t    op_q, op_d;
  logic [32:0] need_q, need_d;
  logic [31:0] ra_q, ra_d;
  logic        bad_q, bad_d;

  logic [IDX_W:0]   cnt_q, cnt_d;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             rd_en;

  // best / target entry, predecessor, successor, first spare
  logic             t_vld_q, t_vld_d, p_vld_q, p_vld_d, n_vld_q, n_vld_d;
  logic [IDX_W-1:0] t_idx_q, t_idx_d, p_idx_q, p_idx_d, n_idx_q, n_idx_d;
  logic [31:0]      t_base_q, t_base_d, t_len_q, t_len_d;
  logic [31:0]      p_base_q, p_base_d, p_len_q, p_len_d;
  logic [31:0]      n_base_q, n_base_d, n_len_q, n_len_d;
  logic             f_vld_q, f_vld_d;
  logic [IDX_W-1:0] f_idx_q, f_idx_d;

  bfea_out_t res_q, res_d;
  logic      res_vld_q, res_vld_d;

  // extent RAM: {base, length}
  logic [63:0]      ext_mem_q [NUM_EXTENTS];
  logic [63:0]      mem_rd_q;
  logic             rd_init0_q;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [63:0]      wr_data;

  logic        accept, scan_done, cfg_we;
  logic [31:0] rd_base, rd_len;
  logic        rd_live;
  logic [32:0] rd_end, end_t, end_p, after;
  logic [31:0] new_len;

  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign busy_o      = (state_q != S_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o    = res_q;

  assign scan_done = (cnt_q == ScanEnd) && !rd_vld_q;
  assign rd_en     = (state_q == S_SCAN_A || state_q == S_SCAN_T || state_q == S_SCAN_PN)
                     && (cnt_q != ScanEnd);

  assign rd_base = rd_init0_q ? pool_start_q  : mem_rd_q[63:32];
  assign rd_len  = rd_init0_q ? pool_length_q : mem_rd_q[31:0];
  assign rd_live = live_q[rd_idx_q];
  assign rd_end  = {1'b0, rd_base} + {1'b0, rd_len};
  assign end_t   = {1'b0, t_base_q} + {1'b0, t_len_q};
  assign end_p   = {1'b0, p_base_q} + {1'b0, p_len_q};
  assign after   = {1'b0, ra_q} + {1'b0, op_q.release_bytes};
  assign new_len = t_len_q - need_q[31:0];

  // RAM: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ext_mem_q[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      mem_rd_q   <= ext_mem_q[cnt_q[IDX_W-1:0]];
      rd_init0_q <= init0_q && (cnt_q[IDX_W-1:0] == '0);
      rd_idx_q   <= cnt_q[IDX_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (item_i.command == CMD_ALLOC) begin
            state_d = S_SCAN_A;
          end else if (bad_d) begin
            state_d = S_UPDATE;
          end else begin
            state_d = S_SCAN_T;
          end
        end
      end
      S_SCAN_A: begin
        if (scan_done) state_d = S_UPDATE;
      end
      S_SCAN_T: begin
        if (scan_done) state_d = t_vld_q ? S_SCAN_PN : S_UPDATE;
      end
      S_SCAN_PN: begin
        if (scan_done) state_d = S_UPDATE;
      end
      S_UPDATE: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath: scan tracking, write-back and result
  always_comb begin
    logic [32:0] top;
    logic        ahead_t;
    op_d = op_q; need_d = need_q; ra_d = ra_q; bad_d = bad_q;
    cnt_d = cnt_q;
    t_vld_d = t_vld_q; t_idx_d = t_idx_q; t_base_d = t_base_q; t_len_d = t_len_q;
    p_vld_d = p_vld_q; p_idx_d = p_idx_q; p_base_d = p_base_q; p_len_d = p_len_q;
    n_vld_d = n_vld_q; n_idx_d = n_idx_q; n_base_d = n_base_q; n_len_d = n_len_q;
    f_vld_d = f_vld_q; f_idx_d = f_idx_q;
    live_d = live_q; init0_d = init0_q;
    res_d = res_q; res_vld_d = 1'b0;
    wr_en = 1'b0; wr_idx = t_idx_q; wr_data = {t_base_q, t_len_q};
    top = {1'b0, pool_start_q} + {1'b0, pool_length_q};
    ahead_t = (rd_base < t_base_q) || ((rd_base == t_base_q) && (rd_idx_q < t_idx_q));

    if (cnt_q != ScanEnd && rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        // capture the item and clear the trackers
        cnt_d = '0;
        t_vld_d = 1'b0; p_vld_d = 1'b0; n_vld_d = 1'b0; f_vld_d = 1'b0;
        bad_d = (item_i.release_addr < pool_start_q) || ({1'b0, item_i.release_addr} > top);
        if (accept) begin
          op_d   = item_i;
          need_d = ({1'b0, item_i.request_bytes} + GranAdd) & GranMask;
          ra_d   = item_i.release_addr - 32'(GRANULE_BYTES);
        end
      end
      S_SCAN_A: begin
        // keep the smallest fitting extent, lowest address on a tie
        if (rd_vld_q && rd_live && ({1'b0, rd_len} >= need_q) &&
            (!t_vld_q || rd_len < t_len_q ||
             (rd_len == t_len_q && rd_base < t_base_q))) begin
          t_vld_d = 1'b1; t_idx_d = rd_idx_q; t_base_d = rd_base; t_len_d = rd_len;
        end
        if (scan_done) cnt_d = '0;
      end
      S_SCAN_T: begin
        // first extent in order whose end reaches the block; first spare
        if (rd_vld_q && rd_live && ({1'b0, ra_q} <= rd_end) &&
            (!t_vld_q || rd_base < t_base_q)) begin
          t_vld_d = 1'b1; t_idx_d = rd_idx_q; t_base_d = rd_base; t_len_d = rd_len;
        end
        if (rd_vld_q && !rd_live && !f_vld_q) begin
          f_vld_d = 1'b1; f_idx_d = rd_idx_q;
        end
        if (scan_done) cnt_d = '0;
      end
      S_SCAN_PN: begin
        // nearest extents before and after the target
        if (rd_vld_q && rd_live && rd_idx_q != t_idx_q) begin
          if (ahead_t) begin
            if (!p_vld_q || p_base_q <= rd_base) begin
              p_vld_d = 1'b1; p_idx_d = rd_idx_q; p_base_d = rd_base; p_len_d = rd_len;
            end
          end else if (!n_vld_q || rd_base < n_base_q) begin
            n_vld_d = 1'b1; n_idx_d = rd_idx_q; n_base_d = rd_base; n_len_d = rd_len;
          end
        end
        if (scan_done) cnt_d = '0;
      end
      S_UPDATE: begin
        res_vld_d = 1'b1;
        res_d = '0;
        if (op_q.command == CMD_ALLOC) begin
          if (!t_vld_q) begin
            res_d.status = STAT_NO_FIT;
          end else begin
            // carve from the high end
            wr_en = 1'b1; wr_idx = t_idx_q; wr_data = {t_base_q, new_len};
            if (new_len == '0) live_d[t_idx_q] = 1'b0;
            res_d.status      = STAT_OK;
            res_d.grant_addr  = t_base_q + new_len + 32'(GRANULE_BYTES);
            res_d.grant_bytes = need_q[31:0];
          end
        end else if (bad_q) begin
          res_d.status = STAT_RANGE;
        end else if (t_vld_q && {1'b0, ra_q} == end_t) begin
          // grow the target, absorb the successor if it touches
          wr_en = 1'b1; wr_idx = t_idx_q;
          if (n_vld_q && after == {1'b0, n_base_q}) begin
            wr_data = {t_base_q, t_len_q + op_q.release_bytes + n_len_q};
            live_d[n_idx_q] = 1'b0;
          end else begin
            wr_data = {t_base_q, t_len_q + op_q.release_bytes};
          end
          res_d.status = STAT_OK;
        end else if (t_vld_q && after == {1'b0, t_base_q}) begin
          // join the front, fold into the predecessor if it touches
          wr_en = 1'b1;
          if (p_vld_q && {1'b0, ra_q} == end_p) begin
            wr_idx  = p_idx_q;
            wr_data = {p_base_q, p_len_q + op_q.release_bytes + t_len_q};
            live_d[t_idx_q] = 1'b0;
          end else begin
            wr_idx  = t_idx_q;
            wr_data = {ra_q, t_len_q + op_q.release_bytes};
          end
          res_d.status = STAT_OK;
        end else if (f_vld_q) begin
          // take the lowest spare entry
          wr_en = 1'b1; wr_idx = f_idx_q; wr_data = {ra_q, op_q.release_bytes};
          live_d[f_idx_q] = 1'b1;
          res_d.status = STAT_OK;
        end else begin
          res_d.status = STAT_FULL;
        end
        if (wr_en && wr_idx == '0) init0_d = 1'b0;
      end
      default: ;
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      pool_start_q  <= '0;
      pool_length_q <= '0;
      live_q        <= NUM_EXTENTS'(1);
      init0_q       <= 1'b1;
      cnt_q         <= '0;
      rd_vld_q      <= 1'b0;
      res_vld_q     <= 1'b0;
      t_vld_q       <= 1'b0;
      p_vld_q       <= 1'b0;
      n_vld_q       <= 1'b0;
      f_vld_q       <= 1'b0;
      bad_q         <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_en;
      res_vld_q <= res_vld_d;
      t_vld_q   <= t_vld_d;
      p_vld_q   <= p_vld_d;
      n_vld_q   <= n_vld_d;
      f_vld_q   <= f_vld_d;
      bad_q     <= bad_d;
      if (cfg_we) begin
        if (cfg_index_i == CFG_POOL_START) begin
          pool_start_q <= cfg_data_i;
        end else begin
          pool_length_q <= cfg_data_i;
        end
        live_q  <= NUM_EXTENTS'(1);
        init0_q <= 1'b1;
      end else begin
        live_q  <= live_d;
        init0_q <= init0_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q <= op_d; need_q <= need_d; ra_q <= ra_d;
    t_idx_q <= t_idx_d; t_base_q <= t_base_d; t_len_q <= t_len_d;
    p_idx_q <= p_idx_d; p_base_q <= p_base_d; p_len_q <= p_len_d;
    n_idx_q <= n_idx_d; n_base_q <= n_base_d; n_len_q <= n_len_d;
    f_idx_q <= f_idx_d;
    res_q   <= res_d;
  end

endmodule

// ===== rtl/core/bfea_checker.sv =====
// Port-level checks for the best-fit extent allocator, bound to the top.
// Depends on bfea_pkg and best_fit_extent_allocator_top_macros.svh.
`include "best_fit_extent_allocator_top_macros.svh"

module bfea_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input logic                result_valid_o,
  input bfea_pkg::bfea_out_t result_o
);
  import bfea_pkg::*;

  // busy follows an accepted item
  `BFEA_ASSERT_NEXT(a_busy_after_accept, start_i && !busy_o, busy_o, "busy missing after accept")
  // one strobe per item
  `BFEA_ASSERT_NEXT(a_single_strobe, result_valid_o, !result_valid_o, "result held over")
  // the result closes the item
  `BFEA_ASSERT_NOW(a_idle_at_result, result_valid_o, !busy_o, "busy during result")
  // failed items grant nothing
  `BFEA_ASSERT_NOW(a_zero_on_error, result_valid_o && result_o.status != STAT_OK,
                   result_o.grant_addr == '0 && result_o.grant_bytes == '0,
                   "grant on failed item")

endmodule

bind best_fit_extent_allocator_top bfea_checker u_bfea_checker (.*);

// ===== tb/sv/tb_best_fit_extent_allocator_top.sv =====
// Self-checking bench for the best-fit extent allocator: random and directed items.
// It predicts each result with its own copy of the extent table and compares them.
// Depends on bfea_pkg and best_fit_extent_allocator_top.
module tb_best_fit_extent_allocator_top;
  import bfea_pkg::*;

  localparam int SETTLE_CYCLES = 160;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    bfea_in_t item;
    bit       reuse_grant;
  } pending_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic       busy_o;
  bfea_in_t   item_i = '0;
  logic       result_valid_o;
  bfea_out_t  result_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = CFG_POOL_START;
  logic [31:0] cfg_data_i = '0;

  pending_t    pending_q[$];
  bfea_out_t   expected_q[$];
  logic [31:0] grant_addr_q[$];
  logic [31:0] grant_bytes_q[$];
  int          idle_pct = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  // Shadow of the extent table and the pool registers
  logic [31:0] pool_base = '0;
  logic [31:0] pool_size = '0;
  logic [31:0] ext_base[NUM_EXTENTS];
  logic [31:0] ext_len[NUM_EXTENTS];
  bit          ext_live[NUM_EXTENTS];

  best_fit_extent_allocator_top u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .result_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  function automatic void rebuild_table();
    for (int i = 0; i < NUM_EXTENTS; i++) begin
      ext_base[i] = '0;
      ext_len[i] = '0;
      ext_live[i] = 1'b0;
    end
    ext_base[0] = pool_base;
    ext_len[0] = pool_size;
    ext_live[0] = 1'b1;
  endfunction

  // Address order: base first, then table index
  function automatic bit is_ahead(int a, int b);
    if (ext_base[a] != ext_base[b]) return ext_base[a] < ext_base[b];
    return a < b;
  endfunction

  function automatic logic [63:0] end_at(int i);
    return {32'd0, ext_base[i]} + {32'd0, ext_len[i]};
  endfunction

  function automatic logic [1:0] place_extent(logic [31:0] b, logic [31:0] l);
    for (int i = 0; i < NUM_EXTENTS; i++) begin
      if (!ext_live[i]) begin
        ext_base[i] = b;
        ext_len[i] = l;
        ext_live[i] = 1'b1;
        return STAT_OK;
      end
    end
    return STAT_FULL;
  endfunction

  function automatic bfea_out_t carve_block(logic [31:0] req);
    bfea_out_t   r;
    logic [63:0] need;
    int          best;
    r = '0;
    best = -1;
    need = {32'd0, req} + GRANULE_BYTES;
    if (need % GRANULE_BYTES != 0) need += GRANULE_BYTES - need % GRANULE_BYTES;
    for (int i = 0; i < NUM_EXTENTS; i++) begin
      if (ext_live[i] && {32'd0, ext_len[i]} >= need) begin
        if (best < 0 || ext_len[i] < ext_len[best] ||
            (ext_len[i] == ext_len[best] && is_ahead(i, best))) best = i;
      end
    end
    if (best < 0) begin
      r.status = STAT_NO_FIT;
      return r;
    end
    ext_len[best] = ext_len[best] - need[31:0];
    r.status = STAT_OK;
    r.grant_addr = 32'(end_at(best) + GRANULE_BYTES);
    r.grant_bytes = need[31:0];
    if (ext_len[best] == 0) ext_live[best] = 1'b0;
    return r;
  endfunction

  function automatic bfea_out_t return_block(logic [31:0] addr, logic [31:0] bytes);
    bfea_out_t   r;
    logic [31:0] blk;
    logic [63:0] blk_end;
    int          tgt, prv, nxt;
    r = '0;
    tgt = -1;
    prv = -1;
    nxt = -1;
    if (addr < pool_base || {32'd0, addr} > {32'd0, pool_base} + {32'd0, pool_size}) begin
      r.status = STAT_RANGE;
      return r;
    end
    blk = addr - GRANULE_BYTES;
    for (int i = 0; i < NUM_EXTENTS; i++)
      if (ext_live[i] && {32'd0, blk} <= end_at(i) && (tgt < 0 || is_ahead(i, tgt))) tgt = i;
    if (tgt < 0) begin
      r.status = place_extent(blk, bytes);
      return r;
    end
    for (int i = 0; i < NUM_EXTENTS; i++) begin
      if (ext_live[i] && i != tgt) begin
        if (is_ahead(i, tgt)) begin
          if (prv < 0 || is_ahead(prv, i)) prv = i;
        end else if (nxt < 0 || is_ahead(i, nxt)) begin
          nxt = i;
        end
      end
    end
    blk_end = {32'd0, blk} + {32'd0, bytes};
    r.status = STAT_OK;
    if ({32'd0, blk} == end_at(tgt)) begin
      // Grow the target, swallowing the next extent if the block bridges them
      if (nxt >= 0 && blk_end == {32'd0, ext_base[nxt]}) begin
        ext_len[tgt] = ext_len[tgt] + bytes + ext_len[nxt];
        ext_live[nxt] = 1'b0;
        ext_base[nxt] = '0;
        ext_len[nxt] = '0;
      end else begin
        ext_len[tgt] = ext_len[tgt] + bytes;
      end
    end else if (blk_end == {32'd0, ext_base[tgt]}) begin
      // Join the front of the target, or fold both into the previous extent
      if (prv >= 0 && {32'd0, blk} == end_at(prv)) begin
        ext_len[prv] = ext_len[prv] + bytes + ext_len[tgt];
        ext_live[tgt] = 1'b0;
        ext_base[tgt] = '0;
        ext_len[tgt] = '0;
      end else begin
        ext_base[tgt] = blk;
        ext_len[tgt] = ext_len[tgt] + bytes;
      end
    end else begin
      r.status = place_extent(blk, bytes);
    end
    return r;
  endfunction

  // Driver: predict on accept, then present the next item or idle
  always @(posedge clk_i) begin
    bfea_out_t exp_res;
    pending_t  nxt_item;
    int        pick;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_POOL_START) pool_base = cfg_data_i;
      else pool_size = cfg_data_i;
      rebuild_table();
      grant_addr_q.delete();
      grant_bytes_q.delete();
    end
    if (start_i && !busy_o) begin
      if (item_i.command == CMD_ALLOC) begin
        exp_res = carve_block(item_i.request_bytes);
        if (exp_res.status == STAT_OK) begin
          grant_addr_q.push_back(exp_res.grant_addr);
          grant_bytes_q.push_back(exp_res.grant_bytes);
        end
      end else begin
        exp_res = return_block(item_i.release_addr, item_i.release_bytes);
      end
      expected_q.push_back(exp_res);
    end
    if (!start_i || !busy_o) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt_item = pending_q.pop_front();
        if (nxt_item.reuse_grant && grant_addr_q.size() != 0) begin
          pick = $urandom_range(grant_addr_q.size() - 1);
          nxt_item.item.release_addr = grant_addr_q[pick];
          nxt_item.item.release_bytes = grant_bytes_q[pick];
          grant_addr_q.delete(pick);
          grant_bytes_q.delete(pick);
        end
        item_i <= nxt_item.item;
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each strobed result with the oldest prediction
  always @(posedge clk_i) begin
    bfea_out_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result_o);
      end else begin
        want = expected_q.pop_front();
        if (result_o.status !== want.status || result_o.grant_addr !== want.grant_addr ||
            result_o.grant_bytes !== want.grant_bytes) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, result_o);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_alloc(logic [31:0] req);
    pending_t p;
    p.item = '0;
    p.item.command = CMD_ALLOC;
    p.item.request_bytes = req;
    p.reuse_grant = 1'b0;
    pending_q.push_back(p);
  endtask

  task automatic push_free(logic [31:0] addr, logic [31:0] bytes, bit reuse);
    pending_t p;
    p.item = '0;
    p.item.command = CMD_FREE;
    p.item.release_addr = addr;
    p.item.release_bytes = bytes;
    p.reuse_grant = reuse;
    pending_q.push_back(p);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || start_i || expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int n, logic [31:0] base, logic [31:0] size, int idle);
    int roll;
    write_reg(CFG_POOL_START, base);
    write_reg(CFG_POOL_LENGTH, size);
    idle_pct = idle;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 55) push_alloc($urandom_range(0, 200));
      else if (roll < 60) push_alloc($urandom);
      else if (roll < 92) push_free('0, '0, 1'b1);
      else if (roll < 96) push_free($urandom, $urandom, 1'b0);
      else push_free(base + $urandom_range(0, size[15:0]), $urandom_range(0, 64) * 8, 1'b0);
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Empty pool after reset: nothing fits, any free above zero is out of range
    push_alloc(32'd0);
    push_free(32'd0, 32'd0, 1'b0);
    push_free(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    drain();
    write_reg(CFG_POOL_START, 32'h0000_1000);
    write_reg(CFG_POOL_LENGTH, 32'h0000_0400);
    // Directed: extremes, best fit, every merge shape and range checks
    push_alloc(32'hFFFF_FFFF);
    push_alloc(32'hFFFF_FFF8);
    push_alloc(32'd0);
    push_alloc(32'd1);
    push_alloc(32'd24);
    push_alloc(32'd100);
    push_free(32'h0000_0FFF, 32'd16, 1'b0);
    push_free(32'h0000_1401, 32'd16, 1'b0);
    push_free(32'h0000_1400, 32'd0, 1'b0);
    push_free('0, '0, 1'b1);
    push_free('0, '0, 1'b1);
    push_alloc(32'd8);
    push_free('0, '0, 1'b1);
    push_free('0, '0, 1'b1);
    push_free('0, '0, 1'b1);
    push_alloc(32'd1000);
    push_alloc(32'd1008);
    push_free(32'h0000_1000, 32'd8, 1'b0);
    drain();
    // Pool at the top of the address space with a wrapping end
    write_reg(CFG_POOL_START, 32'hFFFF_FF00);
    write_reg(CFG_POOL_LENGTH, 32'hFFFF_FFFF);
    push_alloc(32'd16);
    push_alloc(32'hFFFF_FFF0);
    push_free(32'hFFFF_FF00, 32'd8, 1'b0);
    push_free('0, '0, 1'b1);
    drain();
    random_phase(160, 32'h0000_2000, 32'h0000_0800, 0);
    random_phase(160, $urandom & 32'hFFFF_FFF8, $urandom_range(256, 4096), 46);
    random_phase(160, $urandom, $urandom_range(256, 8192), 22);
    random_phase(160, 32'd0, 32'hFFFF_FFFF, 46);
    random_phase(160, 32'hFFFF_F000, 32'hFFFF_FFFF, 0);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bfea_pkg.sv
rtl/core/best_fit_extent_allocator_top.sv
rtl/core/bfea_checker.sv
tb/sv/tb_best_fit_extent_allocator_top.sv
